/* rtl/i8080pd_pkg.sv */
// Shared types, constants and the opcode decode function of the 8080 predecoder.
package i8080pd_pkg;

  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [5:0] {
    CLS_MOV, CLS_MVI, CLS_LXI, CLS_LDA, CLS_STA, CLS_LHLD, CLS_SHLD, CLS_LDAX,
    CLS_STAX, CLS_XCHG, CLS_ADD, CLS_ADI, CLS_ADC, CLS_ACI, CLS_SUB, CLS_SUI,
    CLS_SBB, CLS_SBI, CLS_INR, CLS_DCR, CLS_INX, CLS_DCX, CLS_DAD, CLS_DAA,
    CLS_ANA, CLS_ANI, CLS_XRA, CLS_XRI, CLS_ORA, CLS_ORI, CLS_CMP, CLS_CPI,
    CLS_RLC, CLS_RRC, CLS_RAL, CLS_RAR, CLS_CMA, CLS_CMC, CLS_STC, CLS_JMP,
    CLS_JCC, CLS_CALL, CLS_CCC, CLS_RET, CLS_RCC, CLS_RST, CLS_PCHL, CLS_PUSH,
    CLS_POP, CLS_XTHL, CLS_SPHL, CLS_IN, CLS_OUT, CLS_EI, CLS_DI, CLS_HLT,
    CLS_NOP, CLS_UNKNOWN
  } class_e;

  localparam logic [7:0] OpHlt = 8'h76;
  localparam logic [7:0] OpNop = 8'h00;
  localparam logic [2:0] RegM  = 3'b110;

  typedef struct packed {
    class_e     cls;
    logic [1:0] len;
    logic       mem;
  } dec_t;

  // One assembled instruction handed from the front to the back.
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  op;
    logic [15:0] imm;
  } entry_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [5:0]  instr_class;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [1:0]  reg_pair;
    logic [2:0]  condition;
    logic [5:0]  restart_vector;
    logic        mem_operand;
    logic [15:0] immediate;
    logic [1:0]  instr_length;
  } rec_t;

  function automatic class_e alu_reg_cls(input logic [2:0] d);
    class_e c;
    case (d)
      3'd0: c = CLS_ADD;
      3'd1: c = CLS_ADC;
      3'd2: c = CLS_SUB;
      3'd3: c = CLS_SBB;
      3'd4: c = CLS_ANA;
      3'd5: c = CLS_XRA;
      3'd6: c = CLS_ORA;
      default: c = CLS_CMP;
    endcase
    return c;
  endfunction

  function automatic class_e alu_imm_cls(input logic [2:0] d);
    class_e c;
    case (d)
      3'd0: c = CLS_ADI;
      3'd1: c = CLS_ACI;
      3'd2: c = CLS_SUI;
      3'd3: c = CLS_SBI;
      3'd4: c = CLS_ANI;
      3'd5: c = CLS_XRI;
      3'd6: c = CLS_ORI;
      default: c = CLS_CPI;
    endcase
    return c;
  endfunction

  function automatic class_e acc_op_cls(input logic [2:0] d);
    class_e c;
    case (d)
      3'd0: c = CLS_RLC;
      3'd1: c = CLS_RRC;
      3'd2: c = CLS_RAL;
      3'd3: c = CLS_RAR;
      3'd4: c = CLS_DAA;
      3'd5: c = CLS_CMA;
      3'd6: c = CLS_STC;
      default: c = CLS_CMC;
    endcase
    return c;
  endfunction

  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t       r;
    logic [1:0] g;
    logic [2:0] d;
    logic [2:0] s;
    logic [1:0] p;
    logic [3:0] lo;
    g = op[7:6];
    d = op[5:3];
    s = op[2:0];
    p = op[5:4];
    lo = op[3:0];
    r.cls = CLS_UNKNOWN;
    r.len = 2'd1;
    r.mem = 1'b0;
    case (g)
      2'd1: begin
        if (op == OpHlt) begin
          r.cls = CLS_HLT;
        end else begin
          r.cls = CLS_MOV;
          r.mem = (d == RegM) || (s == RegM);
        end
      end
      2'd2: begin
        r.cls = alu_reg_cls(d);
        r.mem = (s == RegM);
      end
      2'd0: begin
        if (s == 3'd6) begin
          r.cls = CLS_MVI; r.len = 2'd2; r.mem = (d == RegM);
        end else if (s == 3'd4) begin
          r.cls = CLS_INR; r.mem = (d == RegM);
        end else if (s == 3'd5) begin
          r.cls = CLS_DCR; r.mem = (d == RegM);
        end else if (s == 3'd7) begin
          r.cls = acc_op_cls(d);
        end else if (lo == 4'd1) begin
          r.cls = CLS_LXI; r.len = 2'd3;
        end else if (lo == 4'd3) begin
          r.cls = CLS_INX;
        end else if (lo == 4'd11) begin
          r.cls = CLS_DCX;
        end else if (lo == 4'd9) begin
          r.cls = CLS_DAD;
        end else if (lo == 4'd2) begin
          if (!p[1]) begin
            r.cls = CLS_STAX;
          end else begin
            r.cls = p[0] ? CLS_STA : CLS_SHLD; r.len = 2'd3;
          end
        end else if (lo == 4'd10) begin
          if (!p[1]) begin
            r.cls = CLS_LDAX;
          end else begin
            r.cls = p[0] ? CLS_LDA : CLS_LHLD; r.len = 2'd3;
          end
        end else if (op == OpNop) begin
          r.cls = CLS_NOP;
        end
      end
      default: begin
        case (s)
          3'd0: r.cls = CLS_RCC;
          3'd2: begin r.cls = CLS_JCC; r.len = 2'd3; end
          3'd4: begin r.cls = CLS_CCC; r.len = 2'd3; end
          3'd7: r.cls = CLS_RST;
          3'd6: begin r.cls = alu_imm_cls(d); r.len = 2'd2; end
          3'd1: begin
            if (!d[0])          r.cls = CLS_POP;
            else if (d == 3'd1) r.cls = CLS_RET;
            else if (d == 3'd5) r.cls = CLS_PCHL;
            else if (d == 3'd7) r.cls = CLS_SPHL;
          end
          3'd5: begin
            if (!d[0]) begin
              r.cls = CLS_PUSH;
            end else if (d == 3'd1) begin
              r.cls = CLS_CALL; r.len = 2'd3;
            end
          end
          default: begin
            case (d)
              3'd0: begin r.cls = CLS_JMP; r.len = 2'd3; end
              3'd2: begin r.cls = CLS_OUT; r.len = 2'd2; end
              3'd3: begin r.cls = CLS_IN;  r.len = 2'd2; end
              3'd4: r.cls = CLS_XTHL;
              3'd5: r.cls = CLS_XCHG;
              3'd6: r.cls = CLS_DI;
              3'd7: r.cls = CLS_EI;
              default: r.cls = CLS_UNKNOWN;
            endcase
          end
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/i8080pd_if.sv */
// Valid/ready channel interfaces for code bytes and decoded records.
interface i8080pd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface i8080pd_rec_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_address;
  logic [7:0]  opcode;
  logic [5:0]  instr_class;
  logic [2:0]  dest_reg;
  logic [2:0]  src_reg;
  logic [1:0]  reg_pair;
  logic [2:0]  condition;
  logic [5:0]  restart_vector;
  logic        mem_operand;
  logic [15:0] immediate;
  logic [1:0]  instr_length;

  modport source (
    output valid, output instr_address, output opcode, output instr_class,
    output dest_reg, output src_reg, output reg_pair, output condition,
    output restart_vector, output mem_operand, output immediate,
    output instr_length, input ready
  );
  modport sink (
    input valid, input instr_address, input opcode, input instr_class,
    input dest_reg, input src_reg, input reg_pair, input condition,
    input restart_vector, input mem_operand, input immediate,
    input instr_length, output ready
  );
endinterface

/* rtl/i8080pd_front.sv */
// Front end: counts operand bytes and assembles complete instructions.
module i8080pd_front import i8080pd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  i8080pd_byte_if.sink byte_i,
  input  logic   full_i,
  output logic   push_o,
  output entry_t entry_o
);

  logic [7:0]  held_op_q, held_op_d;
  logic [1:0]  remain_q, remain_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] start_q, start_d;
  logic [15:0] addr_q, addr_d;

  logic accept;
  logic done;
  dec_t dec_new;
  dec_t dec_held;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign dec_new      = decode_op(byte_i.code_byte);
  assign dec_held     = decode_op(held_op_q);

  always_comb begin
    held_op_d = held_op_q;
    remain_d  = remain_q;
    low_d     = low_q;
    start_d   = start_q;
    addr_d    = addr_q;
    done      = 1'b0;
    entry_o   = '0;
    if (remain_q == 2'd0) begin
      done         = (dec_new.len == 2'd1);
      entry_o.addr = addr_q;
      entry_o.op   = byte_i.code_byte;
      entry_o.imm  = '0;
    end else begin
      done         = (remain_q != 2'd2);
      entry_o.addr = start_q;
      entry_o.op   = held_op_q;
      entry_o.imm  = (dec_held.len == 2'd3) ? {byte_i.code_byte, low_q}
                                            : {8'h00, byte_i.code_byte};
    end
    if (accept) begin
      addr_d = addr_q + 16'd1;
      if (remain_q == 2'd0) begin
        held_op_d = byte_i.code_byte;
        start_d   = addr_q;
        low_d     = '0;
        remain_d  = dec_new.len - 2'd1;
      end else if (remain_q == 2'd2) begin
        low_d    = byte_i.code_byte;
        remain_d = 2'd1;
      end else begin
        remain_d = 2'd0;
      end
    end
  end

  assign push_o = accept && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_op_q <= '0;
      remain_q  <= '0;
      low_q     <= '0;
      start_q   <= '0;
      addr_q    <= '0;
    end else begin
      held_op_q <= held_op_d;
      remain_q  <= remain_d;
      low_q     <= low_d;
      start_q   <= start_d;
      addr_q    <= addr_d;
    end
  end

endmodule

/* rtl/i8080pd_queue.sv */
// Short flip-flop queue of assembled instructions between front and back.
module i8080pd_queue import i8080pd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

/* rtl/i8080pd_back.sv */
// Back end: decodes a queued instruction into a record and holds it for the sink.
module i8080pd_back import i8080pd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  entry_t entry_i,
  output logic   pop_o,
  i8080pd_rec_if.source rec_o
);

  logic valid_q, valid_d;
  rec_t rec_q, rec_d;
  dec_t dec;

  assign dec   = decode_op(entry_i.op);
  // Advance when the output register is empty or its beat leaves this cycle.
  assign pop_o = valid_i && (!valid_q || rec_o.ready);

  always_comb begin
    rec_d.instr_address  = entry_i.addr;
    rec_d.opcode         = entry_i.op;
    rec_d.instr_class    = dec.cls;
    rec_d.dest_reg       = entry_i.op[5:3];
    rec_d.src_reg        = entry_i.op[2:0];
    rec_d.reg_pair       = entry_i.op[5:4];
    rec_d.condition      = entry_i.op[5:3];
    rec_d.restart_vector = (dec.cls == CLS_RST) ? {entry_i.op[5:3], 3'b000} : 6'd0;
    rec_d.mem_operand    = dec.mem;
    rec_d.immediate      = entry_i.imm;
    rec_d.instr_length   = dec.len;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (rec_o.ready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o.valid          = valid_q;
  assign rec_o.instr_address  = rec_q.instr_address;
  assign rec_o.opcode         = rec_q.opcode;
  assign rec_o.instr_class    = rec_q.instr_class;
  assign rec_o.dest_reg       = rec_q.dest_reg;
  assign rec_o.src_reg        = rec_q.src_reg;
  assign rec_o.reg_pair       = rec_q.reg_pair;
  assign rec_o.condition      = rec_q.condition;
  assign rec_o.restart_vector = rec_q.restart_vector;
  assign rec_o.mem_operand    = rec_q.mem_operand;
  assign rec_o.immediate      = rec_q.immediate;
  assign rec_o.instr_length   = rec_q.instr_length;

endmodule

/* rtl/i8080_instruction_predecoder.sv */
// Top level of the 8080 instruction predecoder: front, queue and back end.
//
//   channel  dir  handshake      beat
//   byte_i   in   valid/ready    one program byte (code_byte)
//   rec_o    out  valid/ready    one decoded instruction record
//
// One byte is taken per cycle while the queue is not full; the record of an
// instruction is queued on its last byte, then held in the output register.
// Reset clears the byte counter, stream offset, queue and output valid.
// A stalled sink fills the output register and then the queue (QueueDepth
// entries); byte_i.ready drops only when the queue is full.
module i8080_instruction_predecoder import i8080pd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input logic clk_i,
  input logic rst_ni,
  i8080pd_byte_if.sink  byte_i,
  i8080pd_rec_if.source rec_o
);

  logic   full;
  logic   push;
  entry_t front_entry;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  i8080pd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  i8080pd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  i8080pd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (pop),
    .rec_o   (rec_o)
  );

endmodule

/* tb/sv/i8080pd_decode_checker.sv */
// Watches both predecoder channels, predicts every decoded record and compares it.
module i8080pd_decode_checker import i8080pd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i8080pd_byte_if     byte_i,
  i8080pd_rec_if      rec_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned records_o
);

  // Single-opcode encodings that the table below singles out.
  localparam logic [7:0] OpShld = 8'h22;
  localparam logic [7:0] OpLhld = 8'h2A;
  localparam logic [7:0] OpSta  = 8'h32;
  localparam logic [7:0] OpLda  = 8'h3A;
  localparam logic [7:0] OpJmp  = 8'hC3;
  localparam logic [7:0] OpRet  = 8'hC9;
  localparam logic [7:0] OpCall = 8'hCD;
  localparam logic [7:0] OpOut  = 8'hD3;
  localparam logic [7:0] OpIn   = 8'hDB;
  localparam logic [7:0] OpXthl = 8'hE3;
  localparam logic [7:0] OpPchl = 8'hE9;
  localparam logic [7:0] OpXchg = 8'hEB;
  localparam logic [7:0] OpDi   = 8'hF3;
  localparam logic [7:0] OpSphl = 8'hF9;
  localparam logic [7:0] OpEi   = 8'hFB;

  typedef struct packed {
    class_e     cls;
    logic [1:0] len;
    logic       mem;
  } op_info_t;

  logic [7:0]  held_op;
  logic [1:0]  operands_left;
  logic [7:0]  low_byte;
  logic [15:0] op_addr;
  logic [15:0] next_addr;
  rec_t        expected_records [$];
  rec_t        want;
  int unsigned err_cnt = 0;
  int unsigned rec_cnt = 0;

  assign errors_o  = err_cnt;
  assign records_o = rec_cnt;

  function automatic op_info_t classify(input logic [7:0] op);
    op_info_t   r;
    logic [2:0] d;
    logic [2:0] s;
    d = op[5:3];
    s = op[2:0];
    r.cls = CLS_UNKNOWN;
    r.len = 2'd1;
    r.mem = 1'b0;
    casez (op)
      OpHlt:       r.cls = CLS_HLT;
      8'b01??????: begin
        r.cls = CLS_MOV;
        r.mem = (d == RegM) || (s == RegM);
      end
      8'b10??????: begin
        case (d)
          3'd0: r.cls = CLS_ADD;
          3'd1: r.cls = CLS_ADC;
          3'd2: r.cls = CLS_SUB;
          3'd3: r.cls = CLS_SBB;
          3'd4: r.cls = CLS_ANA;
          3'd5: r.cls = CLS_XRA;
          3'd6: r.cls = CLS_ORA;
          default: r.cls = CLS_CMP;
        endcase
        r.mem = (s == RegM);
      end
      8'b00???110: begin
        r.cls = CLS_MVI;
        r.len = 2'd2;
        r.mem = (d == RegM);
      end
      8'b00???100: begin
        r.cls = CLS_INR;
        r.mem = (d == RegM);
      end
      8'b00???101: begin
        r.cls = CLS_DCR;
        r.mem = (d == RegM);
      end
      8'b00???111: begin
        case (d)
          3'd0: r.cls = CLS_RLC;
          3'd1: r.cls = CLS_RRC;
          3'd2: r.cls = CLS_RAL;
          3'd3: r.cls = CLS_RAR;
          3'd4: r.cls = CLS_DAA;
          3'd5: r.cls = CLS_CMA;
          3'd6: r.cls = CLS_STC;
          default: r.cls = CLS_CMC;
        endcase
      end
      8'b00??0001: begin
        r.cls = CLS_LXI;
        r.len = 2'd3;
      end
      8'b00??0011: r.cls = CLS_INX;
      8'b00??1011: r.cls = CLS_DCX;
      8'b00??1001: r.cls = CLS_DAD;
      8'b000?0010: r.cls = CLS_STAX;
      8'b000?1010: r.cls = CLS_LDAX;
      OpShld:      begin r.cls = CLS_SHLD; r.len = 2'd3; end
      OpLhld:      begin r.cls = CLS_LHLD; r.len = 2'd3; end
      OpSta:       begin r.cls = CLS_STA;  r.len = 2'd3; end
      OpLda:       begin r.cls = CLS_LDA;  r.len = 2'd3; end
      OpNop:       r.cls = CLS_NOP;
      8'b11???000: r.cls = CLS_RCC;
      8'b11???010: begin r.cls = CLS_JCC; r.len = 2'd3; end
      8'b11???100: begin r.cls = CLS_CCC; r.len = 2'd3; end
      8'b11???111: r.cls = CLS_RST;
      8'b11???110: begin
        case (d)
          3'd0: r.cls = CLS_ADI;
          3'd1: r.cls = CLS_ACI;
          3'd2: r.cls = CLS_SUI;
          3'd3: r.cls = CLS_SBI;
          3'd4: r.cls = CLS_ANI;
          3'd5: r.cls = CLS_XRI;
          3'd6: r.cls = CLS_ORI;
          default: r.cls = CLS_CPI;
        endcase
        r.len = 2'd2;
      end
      8'b11??0001: r.cls = CLS_POP;
      8'b11??0101: r.cls = CLS_PUSH;
      OpRet:       r.cls = CLS_RET;
      OpPchl:      r.cls = CLS_PCHL;
      OpSphl:      r.cls = CLS_SPHL;
      OpCall:      begin r.cls = CLS_CALL; r.len = 2'd3; end
      OpJmp:       begin r.cls = CLS_JMP;  r.len = 2'd3; end
      OpOut:       begin r.cls = CLS_OUT;  r.len = 2'd2; end
      OpIn:        begin r.cls = CLS_IN;   r.len = 2'd2; end
      OpXthl:      r.cls = CLS_XTHL;
      OpXchg:      r.cls = CLS_XCHG;
      OpDi:        r.cls = CLS_DI;
      OpEi:        r.cls = CLS_EI;
      default:     r.cls = CLS_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic rec_t make_record(input logic [15:0] addr, input logic [7:0] op,
                                       input logic [15:0] imm);
    op_info_t inf;
    rec_t     r;
    inf = classify(op);
    r.instr_address  = addr;
    r.opcode         = op;
    r.instr_class    = inf.cls;
    r.dest_reg       = op[5:3];
    r.src_reg        = op[2:0];
    r.reg_pair       = op[5:4];
    r.condition      = op[5:3];
    r.restart_vector = (inf.cls == CLS_RST) ? {op[5:3], 3'b000} : 6'd0;
    r.mem_operand    = inf.mem;
    r.immediate      = imm;
    r.instr_length   = inf.len;
    return r;
  endfunction

  task automatic take_code_byte(input logic [7:0] b);
    op_info_t inf;
    if (operands_left == 2'd0) begin
      inf      = classify(b);
      held_op  = b;
      op_addr  = next_addr;
      low_byte = 8'h00;
      if (inf.len == 2'd1) begin
        expected_records = {expected_records, make_record(next_addr, b, 16'h0000)};
      end else begin
        operands_left = inf.len - 2'd1;
      end
    end else if (operands_left == 2'd2) begin
      low_byte      = b;
      operands_left = 2'd1;
    end else begin
      inf = classify(held_op);
      expected_records = {expected_records,
                          make_record(op_addr, held_op,
                                      (inf.len == 2'd3) ? {b, low_byte} : {8'h00, b})};
      operands_left = 2'd0;
    end
    next_addr = next_addr + 16'd1;
  endtask

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      err_cnt++;
      $display("%0t: %s mismatch on record %0d: expected %0h, actual %0h",
               $time, name, rec_cnt, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_op       = 8'h00;
      operands_left = 2'd0;
      low_byte      = 8'h00;
      op_addr       = 16'h0000;
      next_addr     = 16'h0000;
      expected_records.delete();
      pending_o <= 0;
    end else begin
      if (rec_i.valid && rec_i.ready) begin
        if (expected_records.size() == 0) begin
          err_cnt++;
          $display("%0t: record with none expected: expected none, actual opcode %0h at %0h",
                   $time, rec_i.opcode, rec_i.instr_address);
        end else begin
          want = expected_records.pop_front();
          compare_field("instr_address", want.instr_address, rec_i.instr_address);
          compare_field("opcode", want.opcode, rec_i.opcode);
          compare_field("instr_class", want.instr_class, rec_i.instr_class);
          compare_field("dest_reg", want.dest_reg, rec_i.dest_reg);
          compare_field("src_reg", want.src_reg, rec_i.src_reg);
          compare_field("reg_pair", want.reg_pair, rec_i.reg_pair);
          compare_field("condition", want.condition, rec_i.condition);
          compare_field("restart_vector", want.restart_vector, rec_i.restart_vector);
          compare_field("mem_operand", want.mem_operand, rec_i.mem_operand);
          compare_field("immediate", want.immediate, rec_i.immediate);
          compare_field("instr_length", want.instr_length, rec_i.instr_length);
        end
        rec_cnt++;
      end
      if (byte_i.valid && byte_i.ready) begin
        take_code_byte(byte_i.code_byte);
      end
      pending_o <= expected_records.size();
    end
  end

endmodule

/* tb/sv/i8080_instruction_predecoder_test.sv */
// Stimulus, clock, reset and verdict for the 8080 instruction predecoder.
module i8080_instruction_predecoder_test;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned HoldOff     = 8;
  localparam int unsigned SettleCyc   = 20;
  localparam int unsigned PhaseOps    = 64;
  localparam int unsigned PhaseExtra  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int unsigned errors;
  int unsigned pending;
  int unsigned records;
  logic [7:0]  op_order [256];
  logic [7:0]  swap_tmp;
  int unsigned swap_idx;

  // Extremes and special cases: NOP, RST 7 and RST 0, HLT, MOV through memory
  // both ways, plain MOV, ALU on memory, CMP A, undocumented opcodes, MVI M with
  // all ones, LDA with split extreme operands, CALL with all ones, CPI zero.
  logic [7:0] directed_seq [23] = '{
    8'h00, 8'hFF, 8'hC7, 8'h76, 8'h7E, 8'h70, 8'h40, 8'h86, 8'hBF, 8'h08, 8'hCB, 8'hD9,
    8'hFD, 8'h36, 8'hFF, 8'h3A, 8'h00, 8'hFF, 8'hCD, 8'hFF, 8'hFF, 8'hFE, 8'h00
  };

  i8080pd_byte_if byte_ch ();
  i8080pd_rec_if  rec_ch ();

  i8080_instruction_predecoder uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .rec_o  (rec_ch)
  );

  i8080pd_decode_checker decode_chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .byte_i    (byte_ch),
    .rec_i     (rec_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .records_o (records)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    rec_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d records still due", $time, cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned operand_count(input logic [7:0] op);
    casez (op)
      8'b00??0001, 8'b001??010, 8'b11???010, 8'b11???100, 8'b11000011, 8'b11001101: return 2;
      8'b00???110, 8'b11???110, 8'b11010011, 8'b11011011: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.code_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Opcode followed by its operands; operands lean toward all zeros and all ones.
  task automatic send_instr(input logic [7:0] op);
    int unsigned pick;
    logic [7:0]  v;
    send_byte(op);
    repeat (operand_count(op)) begin
      pick = $urandom_range(0, 3);
      v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      send_byte(v);
    end
  endtask

  // Hold the sender until every predicted record has come out.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned first);
    for (int unsigned i = first; i < first + PhaseOps; i++) send_instr(op_order[i]);
    repeat (PhaseExtra) send_instr(8'($urandom_range(0, 255)));
  endtask

  initial begin
    byte_ch.valid     <= 1'b0;
    byte_ch.code_byte <= 8'h00;
    for (int i = 0; i < 256; i++) op_order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      swap_idx = $urandom_range(0, i);
      swap_tmp = op_order[i];
      op_order[i] = op_order[swap_idx];
      op_order[swap_idx] = swap_tmp;
    end
    @(posedge rst_n);
    @(posedge clk);

    // no idling: directed beats first
    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    // stop in the middle of LXI H; nothing may come out until the last byte
    send_byte(8'h21);
    send_byte(8'h34);
    drain();
    repeat (HoldOff) @(posedge clk);
    send_byte(8'h12);
    drain();
    run_phase(0);
    drain();

    send_idle  = 48;
    recv_stall <= 0;
    run_phase(PhaseOps);
    drain();

    send_idle  = 0;
    recv_stall <= 48;
    run_phase(2 * PhaseOps);
    drain();

    send_idle  = 15;
    recv_stall <= 15;
    run_phase(3 * PhaseOps);
    // leave a JMP unfinished at the end of the stream
    send_byte(8'hC3);
    send_byte(8'h12);
    drain();
    repeat (SettleCyc) @(posedge clk);

    $display("Ran %0d code bytes into %0d checked records: every opcode, a stalled operand,",
             bytes_sent, records);
    $display("an unfinished trailing instruction, and sender/receiver idling at 0, 15 and 48%%.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
